FILE: hdl/hld_pkg.sv
// Shared types and constants for the haplotype linkage disequilibrium block.
package hld_pkg;

  localparam int FRAC_BITS = 15;
  localparam int MAX_SAMPLES = 4096;
  localparam logic [15:0] ONE_Q = 16'd32768;
  localparam int REM_W = 62;

  localparam logic [1:0] REG_ALLELE_A = 2'd0;
  localparam logic [1:0] REG_ALLELE_B = 2'd1;
  localparam logic [1:0] REG_FREQ_A = 2'd2;
  localparam logic [1:0] REG_FREQ_B = 2'd3;

  typedef struct packed {
    logic count;
    logic ld_pab;
    logic ld_dp;
    logic ld_r2;
    logic step;
    logic mul1;
    logic diff;
    logic mul2;
    logic st_dp;
    logic done;
  } cmd_t;

endpackage

FILE: hdl/hld_ctrl.sv
// Controller sequencing the sample count, the three divisions and the result strobe.
module hld_ctrl import hld_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic last_sample,
  output logic busy,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LDP  = 9'b000000010,
    S_PAB  = 9'b000000100,
    S_MUL1 = 9'b000001000,
    S_DIFF = 9'b000010000,
    S_MUL2 = 9'b000100000,
    S_DPD  = 9'b001000000,
    S_R2L  = 9'b010000000,
    S_R2D  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic done_r, done_nxt;
  logic acc;

  assign busy = (state_r != S_IDLE);
  assign acc = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.count = acc;
        if (acc && last_sample) begin
          state_nxt = S_LDP;
        end
      end
      S_LDP: begin
        cmd.ld_pab = 1'b1;
        cnt_nxt = 4'd0;
        state_nxt = S_PAB;
      end
      S_PAB: begin
        cmd.step = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        cmd.ld_dp = 1'b1;
        cnt_nxt = 4'd0;
        state_nxt = S_DPD;
      end
      S_DPD: begin
        cmd.step = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = S_R2L;
        end
      end
      S_R2L: begin
        cmd.st_dp = 1'b1;
        cmd.ld_r2 = 1'b1;
        cnt_nxt = 4'd0;
        state_nxt = S_R2D;
      end
      S_R2D: begin
        cmd.step = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          done_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.done = done_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= 4'd0;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

FILE: hdl/hld_dp.sv
// Datapath: configuration, match counters, products and the shared divider.
module hld_dp import hld_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic [3:0]  first_maternal,
  input  logic [3:0]  first_paternal,
  input  logic [3:0]  second_maternal,
  input  logic [3:0]  second_paternal,
  output logic        out_valid,
  output logic [15:0] out_joint_freq,
  output logic signed [16:0] out_disequilibrium,
  output logic signed [16:0] out_normalized_d,
  output logic [15:0] out_correlation_sq,
  output logic        out_dprime_invalid,
  output logic        out_rsq_invalid,
  output logic [12:0] out_samples_seen
);

  logic [3:0]  allele_a_r, allele_b_r;
  logic [15:0] freq_a_r, freq_b_r;
  logic [13:0] match_r;
  logic [12:0] samp_r, n_r;
  logic [16:0] pa, pb, qa, qb;
  logic [31:0] ab_r, aqb_r, bqa_r, qq_r;
  logic [28:0] va_r, vb_r;
  logic [15:0] pab_r;
  logic        neg_r, dinv_r, rinv_r;
  logic [30:0] dmag_r;
  logic [31:0] dmax_r;
  logic [15:0] dq_r;
  logic [60:0] sq_r;
  logic [57:0] vv_r;
  logic [REM_W-1:0] rem_r, den_r, t, num_ld, den_ld;
  logic [15:0] q_r, rnd, dp_r;
  logic        sat_r, ge;
  logic [30:0] big;
  logic [31:0] dmax_nxt;
  logic [1:0]  inc;
  logic [16:0] qp1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allele_a_r <= 4'd1;
      allele_b_r <= 4'd1;
      freq_a_r <= 16'd0;
      freq_b_r <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ALLELE_A: allele_a_r <= cfg_wdata[3:0];
        REG_ALLELE_B: allele_b_r <= cfg_wdata[3:0];
        REG_FREQ_A: freq_a_r <= cfg_wdata;
        REG_FREQ_B: freq_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign inc = {1'b0, (first_maternal == allele_a_r) && (second_maternal == allele_b_r)}
             + {1'b0, (first_paternal == allele_a_r) && (second_paternal == allele_b_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 14'd0;
      samp_r <= 13'd0;
    end else if (cmd.ld_pab) begin
      match_r <= 14'd0;
      samp_r <= 13'd0;
    end else if (cmd.count && (samp_r < 13'(MAX_SAMPLES))) begin
      match_r <= match_r + {12'd0, inc};
      samp_r <= samp_r + 13'd1;
    end
  end

  assign pa = (freq_a_r > ONE_Q) ? {1'b0, ONE_Q} : {1'b0, freq_a_r};
  assign pb = (freq_b_r > ONE_Q) ? {1'b0, ONE_Q} : {1'b0, freq_b_r};
  assign qa = {1'b0, ONE_Q} - pa;
  assign qb = {1'b0, ONE_Q} - pb;

  always_comb begin
    num_ld = '0;
    den_ld = '0;
    if (cmd.ld_pab) begin
      num_ld = REM_W'({match_r, 15'd0} + {16'd0, samp_r});
      den_ld = REM_W'({samp_r, 1'b0, 16'd0});
    end else if (cmd.ld_dp) begin
      num_ld = REM_W'(dmag_r);
      den_ld = REM_W'(dmax_r);
    end else begin
      num_ld = REM_W'(sq_r);
      den_ld = REM_W'(vv_r);
    end
  end

  assign t = {rem_r[REM_W-2:0], 1'b0};
  assign ge = (t >= den_r);
  assign qp1 = {1'b0, q_r} + 17'd1;
  assign rnd = sat_r ? ONE_Q : qp1[16:1];

  always_ff @(posedge clk) begin
    if (cmd.ld_pab || cmd.ld_dp || cmd.ld_r2) begin
      rem_r <= num_ld;
      den_r <= den_ld;
      q_r <= 16'd0;
      sat_r <= (num_ld >= den_ld);
    end else if (cmd.step) begin
      rem_r <= ge ? t - den_r : t;
      q_r <= {q_r[14:0], ge};
    end
  end

  assign big = {pab_r, 15'd0};
  always_comb begin
    if (big < ab_r[30:0]) begin
      dmax_nxt = (ab_r < qq_r) ? ab_r : qq_r;
    end else begin
      dmax_nxt = (aqb_r < bqa_r) ? aqb_r : bqa_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_pab) begin
      n_r <= samp_r;
    end
    if (cmd.mul1) begin
      pab_r <= (n_r == 13'd0) ? 16'd0 : q_r;
      ab_r <= 32'(pa * pb);
      aqb_r <= 32'(pa * qb);
      bqa_r <= 32'(pb * qa);
      qq_r <= 32'(qa * qb);
      va_r <= 29'(pa * qa);
      vb_r <= 29'(pb * qb);
    end
    if (cmd.diff) begin
      neg_r <= big < ab_r[30:0];
      dmag_r <= (big < ab_r[30:0]) ? ab_r[30:0] - big : big - ab_r[30:0];
      dmax_r <= dmax_nxt;
      dinv_r <= (dmax_nxt == 32'd0);
      rinv_r <= (va_r == 29'd0) || (vb_r == 29'd0);
    end
    if (cmd.mul2) begin
      dq_r <= 16'((dmag_r + 31'd16384) >> FRAC_BITS);
      sq_r <= 61'(dmag_r * dmag_r);
      vv_r <= 58'(va_r * vb_r);
    end
    if (cmd.st_dp) begin
      dp_r <= dinv_r ? 16'd0 : rnd;
    end
    if (cmd.done) begin
      out_joint_freq <= pab_r;
      out_disequilibrium <= neg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});
      out_normalized_d <= neg_r ? -$signed({1'b0, dp_r}) : $signed({1'b0, dp_r});
      out_correlation_sq <= rinv_r ? 16'd0 : rnd;
      out_dprime_invalid <= dinv_r;
      out_rsq_invalid <= rinv_r;
      out_samples_seen <= n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.done;
    end
  end

endmodule

FILE: hdl/haplotype_ld_statistics.sv
// Top level: a sample request is taken each cycle while busy is low.
// A request with in_last_sample high raises busy until the last divider pass ends;
// the result strobe out_valid follows after busy falls, for one cycle.
// The result is computed by three 16-step passes of one shared divider.
// Synchronous reset restores register defaults and clears the counts.
module haplotype_ld_statistics import hld_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_first_maternal,
  input  logic [3:0]  in_first_paternal,
  input  logic [3:0]  in_second_maternal,
  input  logic [3:0]  in_second_paternal,
  input  logic        in_last_sample,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  output logic [15:0] out_joint_freq,
  output logic signed [16:0] out_disequilibrium,
  output logic signed [16:0] out_normalized_d,
  output logic [15:0] out_correlation_sq,
  output logic        out_dprime_invalid,
  output logic        out_rsq_invalid,
  output logic [12:0] out_samples_seen
);

  cmd_t cmd;

  hld_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .last_sample (in_last_sample),
    .busy        (busy),
    .cmd         (cmd)
  );

  hld_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .first_maternal     (in_first_maternal),
    .first_paternal     (in_first_paternal),
    .second_maternal    (in_second_maternal),
    .second_paternal    (in_second_paternal),
    .out_valid          (out_valid),
    .out_joint_freq     (out_joint_freq),
    .out_disequilibrium (out_disequilibrium),
    .out_normalized_d   (out_normalized_d),
    .out_correlation_sq (out_correlation_sq),
    .out_dprime_invalid (out_dprime_invalid),
    .out_rsq_invalid    (out_rsq_invalid),
    .out_samples_seen   (out_samples_seen)
  );

endmodule

FILE: tb/tb_haplotype_ld_statistics.sv
// Self-checking testbench for the haplotype linkage disequilibrium block.
module tb_haplotype_ld_statistics;
  import hld_pkg::*;

  typedef struct packed {
    logic [15:0] joint_freq;
    logic [16:0] diseq;
    logic [16:0] norm_d;
    logic [15:0] corr_sq;
    logic        dp_inv;
    logic        rsq_inv;
    logic [12:0] samples;
  } ld_result_t;

  class ld_scoreboard;
    logic [3:0]   allele_a = 4'd1;
    logic [3:0]   allele_b = 4'd1;
    logic [15:0]  freq_a = '0;
    logic [15:0]  freq_b = '0;
    logic [13:0]  match_cnt = '0;
    logic [12:0]  sample_cnt = '0;
    ld_result_t   pending_q[$];
    int           errors = 0;

    function void write_reg(logic [1:0] addr, logic [15:0] data);
      case (addr)
        REG_ALLELE_A: allele_a = data[3:0];
        REG_ALLELE_B: allele_b = data[3:0];
        REG_FREQ_A: freq_a = data;
        REG_FREQ_B: freq_b = data;
        default: ;
      endcase
    endfunction

    // Quotient num*ONE/den rounded half up, saturated to one.
    function longint unsigned scaled_ratio(logic [127:0] num, logic [127:0] den);
      logic [127:0] q;
      logic [127:0] rem;
      if (num >= den) return ONE_Q;
      q = (num << FRAC_BITS) / den;
      rem = (num << FRAC_BITS) % den;
      if ((rem << 1) >= den) q = q + 1;
      if (q > ONE_Q) q = ONE_Q;
      return q;
    endfunction

    function void note_sample(logic [3:0] fm, logic [3:0] fp, logic [3:0] sm,
                              logic [3:0] sp, logic last);
      longint unsigned n, pa, pb, pab, big, ab, dmag, dq, dmax, va, vb, dp, r2;
      logic neg;
      ld_result_t res;
      if (sample_cnt < MAX_SAMPLES) begin
        if (fm == allele_a && sm == allele_b) match_cnt++;
        if (fp == allele_a && sp == allele_b) match_cnt++;
        sample_cnt++;
      end
      if (!last) return;
      n = sample_cnt;
      pa = (freq_a > ONE_Q) ? ONE_Q : freq_a;
      pb = (freq_b > ONE_Q) ? ONE_Q : freq_b;
      pab = (n != 0) ? (match_cnt * ONE_Q + n) / (2 * n) : 0;
      big = pab << FRAC_BITS;
      ab = pa * pb;
      neg = big < ab;
      dmag = neg ? ab - big : big - ab;
      dq = (dmag + (ONE_Q >> 1)) >> FRAC_BITS;
      if (neg) begin
        dmax = (ab < (ONE_Q - pa) * (ONE_Q - pb)) ? ab : (ONE_Q - pa) * (ONE_Q - pb);
      end else begin
        dmax = (pa * (ONE_Q - pb) < pb * (ONE_Q - pa)) ? pa * (ONE_Q - pb)
                                                       : pb * (ONE_Q - pa);
      end
      dp = (dmax != 0) ? scaled_ratio(dmag, dmax) : 0;
      va = pa * (ONE_Q - pa);
      vb = pb * (ONE_Q - pb);
      r2 = (va != 0 && vb != 0) ?
           scaled_ratio(128'(dmag) * 128'(dmag), 128'(va) * 128'(vb)) : 0;
      res.joint_freq = pab[15:0];
      res.diseq = neg ? 17'(-dq) : 17'(dq);
      res.norm_d = neg ? 17'(-dp) : 17'(dp);
      res.corr_sq = r2[15:0];
      res.dp_inv = (dmax == 0);
      res.rsq_inv = (va == 0 || vb == 0);
      res.samples = n[12:0];
      pending_q.push_back(res);
      match_cnt = '0;
      sample_cnt = '0;
    endfunction

    function void check_result(ld_result_t act);
      ld_result_t exp_r;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result at %0t", $realtime);
        return;
      end
      exp_r = pending_q.pop_front();
      if (act != exp_r) begin
        errors++;
        if (errors <= 10)
          $display({"Mismatch: exp pab=%0d d=%0d dp=%0d r2=%0d inv=%b%b n=%0d",
                    " | act pab=%0d d=%0d dp=%0d r2=%0d inv=%b%b n=%0d"},
                   exp_r.joint_freq, $signed(exp_r.diseq), $signed(exp_r.norm_d),
                   exp_r.corr_sq, exp_r.dp_inv, exp_r.rsq_inv, exp_r.samples,
                   act.joint_freq, $signed(act.diseq), $signed(act.norm_d),
                   act.corr_sq, act.dp_inv, act.rsq_inv, act.samples);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] in_first_maternal = '0;
  logic [3:0] in_first_paternal = '0;
  logic [3:0] in_second_maternal = '0;
  logic [3:0] in_second_paternal = '0;
  logic in_last_sample = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic out_valid;
  logic [15:0] out_joint_freq;
  logic signed [16:0] out_disequilibrium;
  logic signed [16:0] out_normalized_d;
  logic [15:0] out_correlation_sq;
  logic out_dprime_invalid;
  logic out_rsq_invalid;
  logic [12:0] out_samples_seen;

  ld_scoreboard sb = new();
  int stall_cycles = 0;
  int burst_left = 0;

  haplotype_ld_statistics uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    ld_result_t act;
    if (rst_n && out_valid) begin
      act.joint_freq = out_joint_freq;
      act.diseq = out_disequilibrium;
      act.norm_d = out_normalized_d;
      act.corr_sq = out_correlation_sq;
      act.dp_inv = out_dprime_invalid;
      act.rsq_inv = out_rsq_invalid;
      act.samples = out_samples_seen;
      sb.check_result(act);
    end
    if ((start && !busy) || out_valid || !rst_n) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles > 5000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_cfg(logic [1:0] addr, logic [15:0] data);
    @(negedge clk);
    start <= 1'b0;
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    sb.write_reg(addr, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(logic [3:0] fm, logic [3:0] fp, logic [3:0] sm,
                             logic [3:0] sp, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    start <= 1'b1;
    in_first_maternal <= fm;
    in_first_paternal <= fp;
    in_second_maternal <= sm;
    in_second_paternal <= sp;
    in_last_sample <= last;
    do @(posedge clk); while (busy);
    sb.note_sample(fm, fp, sm, sp, last);
  endtask

  function automatic logic [3:0] pick_allele(logic [3:0] target);
    return ($urandom_range(0, 9) < 6) ? target : 4'($urandom_range(0, 15));
  endfunction

  task automatic random_run(int len);
    for (int i = 0; i < len; i++)
      send_sample(pick_allele(sb.allele_a), pick_allele(sb.allele_a),
                  pick_allele(sb.allele_b), pick_allele(sb.allele_b), i == len - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  logic [15:0] freq_pick[6] = '{16'd0, 16'd32768, 16'd65535, 16'd16384, 16'd1, 16'd32767};

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register defaults, then the extremes of the fields and the frequencies.
    send_sample(4'd1, 4'd1, 4'd1, 4'd1, 1'b1);
    wait_drained();
    write_cfg(REG_ALLELE_A, 16'd9);
    write_cfg(REG_ALLELE_B, 16'd0);
    write_cfg(REG_FREQ_A, 16'd32768);
    write_cfg(REG_FREQ_B, 16'd65535);
    send_sample(4'd9, 4'd9, 4'd0, 4'd0, 1'b0);
    send_sample(4'd9, 4'd0, 4'd0, 4'd9, 1'b0);
    send_sample(4'd15, 4'd15, 4'd15, 4'd15, 1'b1);
    wait_drained();
    write_cfg(REG_ALLELE_A, 16'd15);
    write_cfg(REG_ALLELE_B, 16'hFFF7);
    write_cfg(REG_FREQ_A, 16'd16384);
    write_cfg(REG_FREQ_B, 16'd16384);
    send_sample(4'd15, 4'd15, 4'd7, 4'd7, 1'b0);
    send_sample(4'd0, 4'd15, 4'd7, 4'd0, 1'b0);
    send_sample(4'd10, 4'd11, 4'd12, 4'd13, 1'b1);
    send_sample(4'd15, 4'd15, 4'd7, 4'd7, 1'b1);
    send_sample(4'd0, 4'd0, 4'd0, 4'd0, 1'b1);
    wait_drained();
    write_cfg(REG_FREQ_A, 16'd1);
    write_cfg(REG_FREQ_B, 16'd32767);
    send_sample(4'd15, 4'd15, 4'd7, 4'd7, 1'b0);
    send_sample(4'd3, 4'd5, 4'd7, 4'd7, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 31; ph++) begin
      write_cfg(REG_ALLELE_A, 16'($urandom_range(0, 15)));
      write_cfg(REG_ALLELE_B, 16'($urandom_range(0, 15)));
      write_cfg(REG_FREQ_A, ($urandom_range(0, 1) == 1) ? freq_pick[$urandom_range(0, 5)]
                                                        : 16'($urandom_range(0, 65535)));
      write_cfg(REG_FREQ_B, ($urandom_range(0, 1) == 1) ? freq_pick[$urandom_range(0, 5)]
                                                        : 16'($urandom_range(0, 65535)));
      for (int r = 0; r < 4; r++)
        random_run(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                               : $urandom_range(4, 35));
      wait_drained();
    end

    repeat (70) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
